@@ hw/rtl/wbc_pkg.sv @@
// wbc_pkg: shared constants, op codes and types of the word break way counter
// used by wbc_sat_acc and word_break_way_counter; depends on nothing

package wbc_pkg;

	// capacities
	localparam int MAX_TARGET   = 64;
	localparam int MAX_WORDS    = 16;
	localparam int MAX_WORD_LEN = 16;

	// derived widths
	localparam int TLEN_W  = $clog2(MAX_TARGET + 1);
	localparam int TIDX_W  = $clog2(MAX_TARGET);
	localparam int CNT_W   = $clog2(MAX_WORDS + 1);
	localparam int WIDX_W  = $clog2(MAX_WORDS);
	localparam int WLEN_W  = $clog2(MAX_WORD_LEN + 1);
	localparam int KIDX_W  = $clog2(MAX_WORD_LEN);
	localparam int BANK_AW = $clog2(MAX_WORDS * MAX_WORD_LEN);
	localparam int SUM_W   = TLEN_W + 1;

	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// op codes of an input item
	localparam logic [1:0] OP_BANK    = 2'd0;
	localparam logic [1:0] OP_TARGET  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	// control of the shared saturating accumulator
	typedef struct packed {
		logic clr_sum;
		logic clr_flag;
		logic add;
	} acc_ctl_t;

endpackage

@@ hw/rtl/wbc_sat_acc.sv @@
// wbc_sat_acc: shared saturating 32-bit accumulator with sticky overflow flag
// depends on wbc_pkg

module wbc_sat_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wbc_pkg::acc_ctl_t            ctl,
	input  logic [wbc_pkg::COUNT_W-1:0]  addend,
	output logic [wbc_pkg::COUNT_W-1:0]  sum,
	output logic                         sat
);

	logic [wbc_pkg::COUNT_W:0] wide_sum;
	logic [wbc_pkg::COUNT_W-1:0] sum_q;
	logic sat_q;

	// one wide add, carry out means overflow
	assign wide_sum = {1'b0, sum_q} + {1'b0, addend};

	// running sum, payload only
	always_ff @(posedge clk) begin
		if (ctl.clr_sum) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= wide_sum[wbc_pkg::COUNT_W] ? wbc_pkg::COUNT_MAX
				: wide_sum[wbc_pkg::COUNT_W-1:0];
		end
	end

	// sticky overflow flag for a whole compute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (ctl.clr_flag) begin
			sat_q <= 1'b0;
		end else if (ctl.add && wide_sum[wbc_pkg::COUNT_W]) begin
			sat_q <= 1'b1;
		end
	end

	assign sum = sum_q;
	assign sat = sat_q;

endmodule

@@ hw/rtl/word_break_way_counter.sv @@
// word_break_way_counter: top level, load logic, memories and compute sequencer
// depends on wbc_pkg and wbc_sat_acc
//
// Usage: input items carry op, symbol and end_word. Op bank appends a character
// to the open bank word (end_word closes it), op target appends a target
// character, op clear empties the bank and the open word, op compute counts
// the ways the target splits into bank words and emits one result item with
// way_count, saturated and load_error. Only compute gives a result.
// Load and clear items are accepted back to back. A compute walks target
// positions from the end down to zero; at each it tries every bank word,
// comparing one character at a time through the registered memory read
// ports (a read state, then a check state), and adds the suffix count of a
// full match through the one shared saturating adder. in_stall stays high
// for the whole compute. The result sits in an output register; while
// out_stall holds it, the next item is still accepted, but a compute then
// runs and waits to finish until the register is free.
// Reset empties bank and target and clears the error flag and out_valid.

module word_break_way_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  symbol,
	input  logic        end_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] way_count,
	output logic        saturated,
	output logic        load_error
);

	localparam int TLEN_W  = wbc_pkg::TLEN_W;
	localparam int TIDX_W  = wbc_pkg::TIDX_W;
	localparam int CNT_W   = wbc_pkg::CNT_W;
	localparam int WIDX_W  = wbc_pkg::WIDX_W;
	localparam int WLEN_W  = wbc_pkg::WLEN_W;
	localparam int KIDX_W  = wbc_pkg::KIDX_W;
	localparam int BANK_AW = wbc_pkg::BANK_AW;
	localparam int SUM_W   = wbc_pkg::SUM_W;
	localparam int COUNT_W = wbc_pkg::COUNT_W;

	// sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_POS      = 4'd1;
	localparam logic [3:0] ST_WORD     = 4'd2;
	localparam logic [3:0] ST_CMP_RD   = 4'd3;
	localparam logic [3:0] ST_CMP_CHK  = 4'd4;
	localparam logic [3:0] ST_WAYS_RD  = 4'd5;
	localparam logic [3:0] ST_WAYS_ADD = 4'd6;
	localparam logic [3:0] ST_STORE    = 4'd7;
	localparam logic [3:0] ST_OUT      = 4'd8;

	// memories and word length registers
	logic [7:0]         target_mem [wbc_pkg::MAX_TARGET];
	logic [7:0]         bank_mem   [wbc_pkg::MAX_WORDS * wbc_pkg::MAX_WORD_LEN];
	logic [COUNT_W-1:0] ways_mem   [wbc_pkg::MAX_TARGET + 1];
	logic [WLEN_W-1:0]  wlen_q     [wbc_pkg::MAX_WORDS];

	// control state
	logic [3:0]         state_q;
	logic [TLEN_W-1:0]  tlen_q;
	logic [CNT_W-1:0]   wcount_q;
	logic [WLEN_W-1:0]  open_q;
	logic               err_q;
	logic [TLEN_W-1:0]  pos_q;
	logic [CNT_W-1:0]   w_q;
	logic [WLEN_W-1:0]  k_q;
	logic               out_valid_q;

	// payload registers
	logic [COUNT_W-1:0] result_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_sat_q;
	logic               out_err_q;
	logic [7:0]         bank_rd_q;
	logic [7:0]         tgt_rd_q;
	logic [COUNT_W-1:0] ways_rd_q;

	logic               in_acc;
	logic               out_free;
	logic [WLEN_W-1:0]  cur_len;
	logic [SUM_W-1:0]   reach;
	logic [BANK_AW-1:0] bank_raddr;
	logic [BANK_AW-1:0] bank_waddr;
	logic [TIDX_W-1:0]  tgt_raddr;
	logic [TLEN_W-1:0]  ways_raddr;
	logic               ways_we;
	logic [TLEN_W-1:0]  ways_waddr;
	logic [COUNT_W-1:0] ways_wdata;
	logic [WLEN_W-1:0]  close_len;
	wbc_pkg::acc_ctl_t  acc_ctl;
	logic [COUNT_W-1:0] acc_sum;
	logic               acc_sat;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// length of the word under test and the position just past it
	assign cur_len = wlen_q[w_q[WIDX_W-1:0]];
	assign reach   = SUM_W'(pos_q) + SUM_W'(cur_len);

	// read addresses
	assign bank_raddr = BANK_AW'(w_q[WIDX_W-1:0]) * BANK_AW'(wbc_pkg::MAX_WORD_LEN)
		+ BANK_AW'(k_q[KIDX_W-1:0]);
	assign tgt_raddr  = TIDX_W'(pos_q + TLEN_W'(k_q));
	assign ways_raddr = TLEN_W'(reach);
	assign bank_waddr = BANK_AW'(wcount_q[WIDX_W-1:0]) * BANK_AW'(wbc_pkg::MAX_WORD_LEN)
		+ BANK_AW'(open_q[KIDX_W-1:0]);

	// length of a word closed by this item
	assign close_len = (open_q < WLEN_W'(wbc_pkg::MAX_WORD_LEN)) ? open_q + 1'b1 : open_q;

	// suffix table write port: seed at compute start, sums at each position
	always_comb begin
		ways_we    = 1'b0;
		ways_waddr = tlen_q;
		ways_wdata = COUNT_W'(1);
		if (in_acc && op == wbc_pkg::OP_COMPUTE) begin
			ways_we = 1'b1;
		end else if (state_q == ST_STORE) begin
			ways_we    = 1'b1;
			ways_waddr = pos_q;
			ways_wdata = acc_sum;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (ways_we) begin
			ways_mem[ways_waddr] <= ways_wdata;
		end
		ways_rd_q <= ways_mem[ways_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == wbc_pkg::OP_TARGET && tlen_q < TLEN_W'(wbc_pkg::MAX_TARGET)) begin
			target_mem[tlen_q[TIDX_W-1:0]] <= symbol;
		end
		tgt_rd_q <= target_mem[tgt_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == wbc_pkg::OP_BANK && wcount_q < CNT_W'(wbc_pkg::MAX_WORDS)
			&& open_q < WLEN_W'(wbc_pkg::MAX_WORD_LEN)) begin
			bank_mem[bank_waddr] <= symbol;
		end
		bank_rd_q <= bank_mem[bank_raddr];
	end

	// word lengths, written when a word closes
	always_ff @(posedge clk) begin
		if (in_acc && op == wbc_pkg::OP_BANK && wcount_q < CNT_W'(wbc_pkg::MAX_WORDS)
			&& end_word && close_len != '0) begin
			wlen_q[wcount_q[WIDX_W-1:0]] <= close_len;
		end
	end

	// accumulator control
	always_comb begin
		acc_ctl.clr_sum  = (state_q == ST_POS);
		acc_ctl.clr_flag = in_acc && op == wbc_pkg::OP_COMPUTE;
		acc_ctl.add      = (state_q == ST_WAYS_ADD);
	end

	wbc_sat_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.addend (ways_rd_q),
		.sum    (acc_sum),
		.sat    (acc_sat)
	);

	// load logic and compute sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tlen_q   <= '0;
			wcount_q <= '0;
			open_q   <= '0;
			err_q    <= 1'b0;
			pos_q    <= '0;
			w_q      <= '0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (op)
							wbc_pkg::OP_BANK: begin
								if (wcount_q >= CNT_W'(wbc_pkg::MAX_WORDS)) begin
									err_q <= 1'b1;
								end else begin
									if (open_q >= WLEN_W'(wbc_pkg::MAX_WORD_LEN)) begin
										err_q <= 1'b1;
									end
									if (end_word) begin
										if (close_len != '0) begin
											wcount_q <= wcount_q + 1'b1;
										end
										open_q <= '0;
									end else if (open_q < WLEN_W'(wbc_pkg::MAX_WORD_LEN)) begin
										open_q <= open_q + 1'b1;
									end
								end
							end
							wbc_pkg::OP_TARGET: begin
								if (tlen_q < TLEN_W'(wbc_pkg::MAX_TARGET)) begin
									tlen_q <= tlen_q + 1'b1;
								end else begin
									err_q <= 1'b1;
								end
							end
							wbc_pkg::OP_COMPUTE: begin
								pos_q   <= tlen_q;
								state_q <= ST_POS;
							end
							wbc_pkg::OP_CLEAR: begin
								wcount_q <= '0;
								open_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				// step to the next lower position, or finish
				ST_POS: begin
					if (pos_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						pos_q   <= pos_q - 1'b1;
						w_q     <= '0;
						state_q <= ST_WORD;
					end
				end
				// pick the next word that fits in the rest of the target
				ST_WORD: begin
					if (w_q == wcount_q) begin
						state_q <= ST_STORE;
					end else if (cur_len == '0 || reach > SUM_W'(tlen_q)) begin
						w_q <= w_q + 1'b1;
					end else begin
						k_q     <= '0;
						state_q <= ST_CMP_RD;
					end
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_CHK;
				end
				// compare one character
				ST_CMP_CHK: begin
					if (bank_rd_q != tgt_rd_q) begin
						w_q     <= w_q + 1'b1;
						state_q <= ST_WORD;
					end else if (k_q + 1'b1 == cur_len) begin
						state_q <= ST_WAYS_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_CMP_RD;
					end
				end
				ST_WAYS_RD: begin
					state_q <= ST_WAYS_ADD;
				end
				ST_WAYS_ADD: begin
					w_q     <= w_q + 1'b1;
					state_q <= ST_WORD;
				end
				ST_STORE: begin
					state_q <= ST_POS;
				end
				// hand the count to the output register
				ST_OUT: begin
					if (out_free) begin
						tlen_q  <= '0;
						err_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// count of the latest position, one for an empty target
	always_ff @(posedge clk) begin
		if (in_acc && op == wbc_pkg::OP_COMPUTE) begin
			result_q <= COUNT_W'(1);
		end else if (state_q == ST_STORE) begin
			result_q <= acc_sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_count_q <= result_q;
			out_sat_q   <= acc_sat;
			out_err_q   <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign way_count  = out_count_q;
	assign saturated  = out_sat_q;
	assign load_error = out_err_q;

endmodule
